// ----- rtl/core/wildcard_glob_matcher_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the wildcard glob matcher
// Clocked assertion helpers that compile away in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef WILDCARD_GLOB_MATCHER_ASSERT_SVH
`define WILDCARD_GLOB_MATCHER_ASSERT_SVH

`ifndef SYNTHESIS
// Property checked on every rising edge of clk outside reset.
`define WGM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition that must never hold on a rising edge of clk outside reset.
`define WGM_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define WGM_ASSERT(lbl, prop, msg)
`define WGM_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ----- rtl/core/wgm_pkg.sv -----
// ----------------------------------------------------------------------------
// wgm_pkg
// Beat types, character codes and case folding for the glob matcher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wgm_pkg;

    typedef enum logic [1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_APPEND = 2'd1,
        FUNC_SUBJ   = 2'd2,
        FUNC_END    = 2'd3
    } func_t;

    typedef struct packed {
        func_t       func;
        logic [15:0] ch;
    } in_beat_t;

    typedef struct packed {
        logic matched;
        logic pattern_too_long;
    } out_beat_t;

    localparam logic [15:0] CH_NUL     = 16'h0000;
    localparam logic [15:0] CH_ANY_ONE = 16'h003F;
    localparam logic [15:0] CH_ANY_RUN = 16'h002A;
    localparam logic [15:0] CH_LOW_A   = 16'h0061;
    localparam logic [15:0] CH_LOW_Z   = 16'h007A;
    localparam logic [15:0] CASE_DELTA = 16'h0020;

    // ASCII lower-case letters map to upper case; all else passes unchanged.
    function automatic logic [15:0] fold_upper(input logic [15:0] c);
        logic [15:0] r;
        r = c;
        if (c >= CH_LOW_A && c <= CH_LOW_Z)
        begin
            r = c - CASE_DELTA;
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/wgm_pat_store.sv -----
// ----------------------------------------------------------------------------
// wgm_pat_store
// Pattern character store with length and overflow tracking. Produces per
// position wildcard and advance masks for the current subject character.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wgm_pat_store #(
    parameter int PAT_MAX = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         clear,
    input  logic                         append,
    input  logic [15:0]                  wr_ch,
    input  logic [15:0]                  cmp_ch,
    output logic [$clog2(PAT_MAX+1)-1:0] pat_len,
    output logic                         overflow,
    output logic [PAT_MAX-1:0]           star_mask,
    output logic [PAT_MAX-1:0]           adv_mask
);
    import wgm_pkg::*;

    localparam int LW = $clog2(PAT_MAX + 1);
    localparam int AW = $clog2(PAT_MAX);

    // Characters are stored already folded, with their wildcard class.
    logic [15:0]   chr_reg  [PAT_MAX];
    logic          star_reg [PAT_MAX];
    logic          any_reg  [PAT_MAX];
    logic [LW-1:0] len_reg;
    logic [LW-1:0] len_next;
    logic          ovf_reg;
    logic          ovf_next;
    logic          full;
    logic          wr_en;
    logic          active;

    assign full  = (len_reg == LW'(PAT_MAX));
    assign wr_en = append && (wr_ch != CH_NUL) && !full;

    always_comb
    begin
        len_next = len_reg;
        ovf_next = ovf_reg;
        if (clear)
        begin
            len_next = '0;
            ovf_next = 1'b0;
        end
        else if (append && (wr_ch != CH_NUL))
        begin
            if (full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                len_next = len_reg + LW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else
        begin
            len_reg <= len_next;
            ovf_reg <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            chr_reg[len_reg[AW-1:0]]  <= fold_upper(wr_ch);
            star_reg[len_reg[AW-1:0]] <= (wr_ch == CH_ANY_RUN);
            any_reg[len_reg[AW-1:0]]  <= (wr_ch == CH_ANY_ONE);
        end
    end

    // Only positions below the stored length take part in matching.
    always_comb
    begin
        for (int i = 0; i < PAT_MAX; i++)
        begin
            active       = (LW'(i) < len_reg);
            star_mask[i] = active && star_reg[i];
            adv_mask[i]  = active && !star_reg[i] && (any_reg[i] || (chr_reg[i] == cmp_ch));
        end
    end

    assign pat_len  = len_reg;
    assign overflow = ovf_reg;

endmodule

// ----- rtl/core/wgm_closure.sv -----
// ----------------------------------------------------------------------------
// wgm_closure
// Extends a set of pattern positions through runs of '*' using a
// parallel prefix network, so the depth grows with the log of the length.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wgm_closure #(
    parameter int PAT_MAX = 32
) (
    input  logic [PAT_MAX:0]   seed,
    input  logic [PAT_MAX-1:0] star_mask,
    output logic [PAT_MAX:0]   closed
);
    localparam int N   = PAT_MAX + 1;
    localparam int LVL = $clog2(N);

    logic [N-1:0] g [LVL+1];
    logic [N-1:0] p [LVL+1];

    // Position j inherits from j-1 when pattern character j-1 is a star.
    always_comb
    begin
        g[0] = seed;
        p[0] = {star_mask, 1'b0};
        for (int l = 0; l < LVL; l++)
        begin
            for (int j = 0; j < N; j++)
            begin
                if (j >= (1 << l))
                begin
                    g[l+1][j] = g[l][j] | (p[l][j] & g[l][j - (1 << l)]);
                    p[l+1][j] = p[l][j] & p[l][j - (1 << l)];
                end
                else
                begin
                    g[l+1][j] = g[l][j];
                    p[l+1][j] = p[l][j];
                end
            end
        end
    end

    assign closed = g[LVL];

endmodule

// ----- rtl/core/wildcard_glob_matcher.sv -----
// ----------------------------------------------------------------------------
// wildcard_glob_matcher
// Case-insensitive '*' and '?' glob matcher for 16-bit characters.
// ----------------------------------------------------------------------------
// Usage: every input beat carries a function code and a character. A clear
// beat empties the pattern, an append beat adds one pattern character, a
// subject beat feeds one subject character, and an end beat closes the
// subject. Zero characters on append or subject beats are ignored. Only end
// beats produce an output beat, carrying the match flag and a flag that the
// pattern overflowed the PAT_MAX entry store (match is then forced low).
//
// Throughput is one input beat per cycle while no end beat is held back,
// set by the single registered pass through the position-set update. An
// accepted end beat passes through the input register and then sits in the
// output register until the receiver takes it. Reset leaves an empty pattern
// and a fresh subject; the pattern store itself needs no clearing pass. When
// the receiver stalls, the output register holds its beat; non-end beats
// keep flowing, and an end beat waits in the input register until the
// output register frees up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "wildcard_glob_matcher_assert.svh"

module wildcard_glob_matcher #(
    parameter int PAT_MAX = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  wgm_pkg::in_beat_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output wgm_pkg::out_beat_t out_data
);
    import wgm_pkg::*;

    localparam int N  = PAT_MAX + 1;
    localparam int LW = $clog2(PAT_MAX + 1);

    // Input register stage.
    logic      in_valid_reg;
    logic      in_valid_next;
    in_beat_t  in_data_reg;

    // Output register stage.
    logic      out_valid_reg;
    logic      out_valid_next;
    out_beat_t out_data_reg;

    // Live positions are kept as an unclosed seed; the star closure is
    // applied on every read, which gives the same set since closing twice
    // changes nothing. A restart therefore only has to seed position zero,
    // even when the pattern just changed.
    logic [N-1:0] live_reg;
    logic [N-1:0] live_next;
    logic [N-1:0] live_closed;
    logic [N-1:0] step_set;

    logic               out_free;
    logic               s1_fire;
    logic               do_clear;
    logic               do_append;
    logic               is_end;
    logic               ch_nonzero;
    logic [15:0]        subj_fold;
    logic [LW-1:0]      pat_len;
    logic               overflow;
    logic [PAT_MAX-1:0] star_mask;
    logic [PAT_MAX-1:0] adv_mask;

    assign out_free   = !out_valid_reg || out_ready;
    assign is_end     = (in_data_reg.func == FUNC_END);
    assign s1_fire    = in_valid_reg && (!is_end || out_free);
    assign in_ready   = !in_valid_reg || s1_fire;
    assign ch_nonzero = (in_data_reg.ch != CH_NUL);
    assign do_clear   = s1_fire && (in_data_reg.func == FUNC_CLEAR);
    assign do_append  = s1_fire && (in_data_reg.func == FUNC_APPEND);
    assign subj_fold  = fold_upper(in_data_reg.ch);

    wgm_pat_store #(
        .PAT_MAX(PAT_MAX)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (do_clear),
        .append   (do_append),
        .wr_ch    (in_data_reg.ch),
        .cmp_ch   (subj_fold),
        .pat_len  (pat_len),
        .overflow (overflow),
        .star_mask(star_mask),
        .adv_mask (adv_mask)
    );

    wgm_closure #(
        .PAT_MAX(PAT_MAX)
    ) u_closure (
        .seed     (live_reg),
        .star_mask(star_mask),
        .closed   (live_closed)
    );

    // A star position stays live on any character; other positions move one
    // step forward when the character matches. The top position never moves.
    assign step_set = {1'b0, live_closed[PAT_MAX-1:0] & star_mask}
                    | {live_closed[PAT_MAX-1:0] & adv_mask, 1'b0};

    always_comb
    begin
        live_next = live_reg;
        if (s1_fire)
        begin
            unique case (in_data_reg.func)
                FUNC_CLEAR:
                begin
                    live_next = N'(1);
                end
                FUNC_APPEND:
                begin
                    if (ch_nonzero)
                    begin
                        live_next = N'(1);
                    end
                end
                FUNC_SUBJ:
                begin
                    if (ch_nonzero)
                    begin
                        live_next = step_set;
                    end
                end
                FUNC_END:
                begin
                    live_next = N'(1);
                end
                default:
                begin
                    live_next = live_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_ready)
        begin
            in_valid_next = in_valid;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_free)
        begin
            out_valid_next = s1_fire && is_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            live_reg      <= N'(1);
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            live_reg      <= live_next;
        end
    end

    // Payload registers load with their stage and need no reset.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_data_reg <= in_data;
        end
        if (s1_fire && is_end)
        begin
            out_data_reg.matched          <= live_closed[pat_len] && !overflow;
            out_data_reg.pattern_too_long <= overflow;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // An end beat that leaves the input register always lands in the output.
    `WGM_ASSERT(a_end_lands, (s1_fire && is_end) |=> out_valid_reg, "end beat lost")
    // Overflowed patterns never report a match.
    `WGM_ASSERT_NEVER(a_ovf_nomatch, out_valid_reg && out_data_reg.pattern_too_long && out_data_reg.matched, "match with overflow")
    // Stored length never passes the store depth.
    `WGM_ASSERT(a_len_bound, pat_len <= LW'(PAT_MAX), "pattern length out of range")
    // Clear and end beats restart the subject at position zero.
    `WGM_ASSERT(a_restart, (do_clear || (s1_fire && is_end)) |=> (live_reg == N'(1)), "subject not restarted")

endmodule
